FILE: rtl/core/bps_pkg.sv
// Package for the beep pattern sequencer: widths, pattern and command codes,
// the per-pattern setup type and its reset values. No dependencies.
package bps_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int BEEP_W        = 7;
  localparam int HALF_W        = 16;
  localparam int PHASE_W       = 8;
  localparam int PAT_W         = 3;
  localparam int NUM_PAT       = 4;
  localparam int PAT_SEL_W     = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [PAT_W-1:0] PAT_OFF            = 3'd0;
  localparam logic [PAT_W-1:0] PAT_SYNC_ERROR     = 3'd1;
  localparam logic [PAT_W-1:0] PAT_SYNC_DONE      = 3'd2;
  localparam logic [PAT_W-1:0] PAT_PRESET_SET     = 3'd3;
  localparam logic [PAT_W-1:0] PAT_PRESET_DELETED = 3'd4;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_POLL    = 1'b1;

  typedef struct packed {
    logic [BEEP_W-1:0] beeps;
    logic [HALF_W-1:0] half_period;
  } pat_cfg_t;

  typedef pat_cfg_t [NUM_PAT-1:0] pat_cfg_set_t;

  localparam pat_cfg_set_t CFG_RESET = '{
    '{beeps: 7'd2, half_period: 16'd500},
    '{beeps: 7'd1, half_period: 16'd500},
    '{beeps: 7'd1, half_period: 16'd1000},
    '{beeps: 7'd3, half_period: 16'd500}
  };

  function automatic logic is_pattern(input logic [PAT_W-1:0] code);
    return (code == PAT_SYNC_ERROR) || (code == PAT_SYNC_DONE) ||
           (code == PAT_PRESET_SET) || (code == PAT_PRESET_DELETED);
  endfunction

endpackage

FILE: rtl/core/bps_cfg_regs.sv
// Configuration registers of the beep pattern sequencer: beep count and half
// period for each of the four patterns. Depends on bps_pkg.
module bps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
  output bps_pkg::pat_cfg_set_t          cfg
);
  import bps_pkg::*;

  logic [PAT_SEL_W-1:0] sel;

  assign sel = cfg_index[CFG_IDX_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      if (cfg_index[0]) begin
        cfg[sel].half_period <= cfg_data[HALF_W-1:0];
      end else begin
        cfg[sel].beeps <= cfg_data[BEEP_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/bps_player.sv
// Pattern player state of the beep pattern sequencer and the combinational
// update that one request or poll makes to it. Depends on bps_pkg.
module bps_player #(
  parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      command,
  input  logic [bps_pkg::PAT_W-1:0] pattern,
  input  logic [TIME_BITS-1:0]      now_ticks,
  input  bps_pkg::pat_cfg_set_t     cfg,
  output logic                      level_next,
  output logic                      playing_next
);
  import bps_pkg::*;

  localparam int NEED_W = HALF_W + PHASE_W;
  localparam int CMP_W  = (TIME_BITS > NEED_W) ? TIME_BITS : NEED_W;

  logic [PAT_W-1:0]     pending_pattern, pending_pattern_next;
  logic [PAT_W-1:0]     active_pattern, active_pattern_next;
  logic                 playing;
  logic                 level;
  logic [PHASE_W-1:0]   phase_count, phase_count_next;
  logic [TIME_BITS-1:0] start_time, start_time_next;
  logic [PHASE_W-1:0]   target_count, target_count_next;
  logic [HALF_W-1:0]    half_period, half_period_next;

  logic [TIME_BITS-1:0] elapsed;
  logic [NEED_W-1:0]    need;
  logic                 toggle;
  logic [PHASE_W-1:0]   phase_adv;
  logic [PAT_SEL_W-1:0] start_sel;

  assign elapsed   = now_ticks - start_time;
  assign need      = NEED_W'(half_period) * NEED_W'(phase_count);
  assign toggle    = CMP_W'(need) < CMP_W'(elapsed);
  assign phase_adv = toggle ? phase_count + PHASE_W'(1) : phase_count;
  assign start_sel = PAT_SEL_W'(pending_pattern - PAT_W'(1));

  always_comb begin
    pending_pattern_next = pending_pattern;
    active_pattern_next  = active_pattern;
    playing_next         = playing;
    level_next           = level;
    phase_count_next     = phase_count;
    start_time_next      = start_time;
    target_count_next    = target_count;
    half_period_next     = half_period;
    if (command == CMD_REQUEST) begin
      pending_pattern_next = pattern;
    end else if (playing) begin
      if (is_pattern(active_pattern) && (phase_adv <= target_count)) begin
        level_next       = level ^ toggle;
        phase_count_next = phase_adv;
      end else begin
        if (is_pattern(active_pattern)) begin
          phase_count_next = phase_adv;
        end
        playing_next         = 1'b0;
        level_next           = 1'b0;
        pending_pattern_next = PAT_OFF;
        active_pattern_next  = PAT_OFF;
      end
    end else if (active_pattern != pending_pattern) begin
      if (is_pattern(pending_pattern)) begin
        active_pattern_next = pending_pattern;
        playing_next        = 1'b1;
        level_next          = 1'b1;
        phase_count_next    = PHASE_W'(1);
        start_time_next     = now_ticks;
        target_count_next   = {cfg[start_sel].beeps, 1'b0};
        half_period_next    = cfg[start_sel].half_period;
      end else begin
        playing_next         = 1'b0;
        level_next           = 1'b0;
        pending_pattern_next = PAT_OFF;
        active_pattern_next  = PAT_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_pattern <= PAT_OFF;
      active_pattern  <= PAT_OFF;
      playing         <= 1'b0;
      level           <= 1'b0;
      phase_count     <= '0;
    end else if (step) begin
      pending_pattern <= pending_pattern_next;
      active_pattern  <= active_pattern_next;
      playing         <= playing_next;
      level           <= level_next;
      phase_count     <= phase_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      start_time   <= start_time_next;
      target_count <= target_count_next;
      half_period  <= half_period_next;
    end
  end

`ifndef ASSERT_OFF
  a_playing_valid_pattern: assert property (@(posedge clk) disable iff (rst)
    playing |-> is_pattern(active_pattern))
    else $error("playing with an active code that is not a pattern");

  a_silent_when_idle: assert property (@(posedge clk) disable iff (rst)
    !playing |-> !level)
    else $error("buzzer driven while no pattern is playing");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    playing |-> (phase_count != '0) &&
                ({1'b0, phase_count} <= {1'b0, target_count} + 9'd1))
    else $error("phase count outside its range while playing");
`endif

endmodule

FILE: rtl/core/beep_pattern_sequencer.sv
// Channel | Handshake             | Payload
// cfg     | cfg_write             | cfg_index, cfg_data
// in      | in_valid / in_stall   | command, pattern, now_ticks
// out     | out_valid / out_stall | buzzer_on, busy_res
// An accepted word passes an input register, then the player update and the
// result register; one word per cycle sustained while the output does not stall.
// The player state loop (subtract, 16x8 multiply, compare) is combinational.
// Reset clears all control state and loads the default pattern setups.
// A stall on the output holds the result and backs up into in_stall.
module beep_pattern_sequencer #(
  parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [bps_pkg::PAT_W-1:0]      pattern,
  input  logic [TIME_BITS-1:0]           now_ticks,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           buzzer_on,
  output logic                           busy_res
);
  import bps_pkg::*;

  pat_cfg_set_t         cfg;
  logic                 s1_valid;
  logic                 s1_command;
  logic [PAT_W-1:0]     s1_pattern;
  logic [TIME_BITS-1:0] s1_now;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;
  logic                 level_next;
  logic                 playing_next;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  bps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bps_player #(
    .TIME_BITS (TIME_BITS)
  ) u_player (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .command      (s1_command),
    .pattern      (s1_pattern),
    .now_ticks    (s1_now),
    .cfg          (cfg),
    .level_next   (level_next),
    .playing_next (playing_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command <= command;
      s1_pattern <= pattern;
      s1_now     <= now_ticks;
    end
    if (advance) begin
      buzzer_on <= level_next;
      busy_res  <= playing_next;
    end
  end

`ifndef ASSERT_OFF
  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted word did not reach the input register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed word did not produce a result");
`endif

endmodule
